// ===== design/stk_pkg.sv =====
// stk_pkg: shared types and constants for the streaming top-k selector.
// Depends on nothing; imported by stk_cell, stk_chain and the top level.
`timescale 1ns / 1ps
`default_nettype none
package stk_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RPT_W    = 7;
  localparam int SCORE_W  = 16;
  localparam int TAG_W    = 16;
  localparam int TOTAL_W  = 32;

  localparam logic [RPT_W-1:0] RPT_RESET = RPT_W'(64);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   chunk;
    logic [TAG_W-1:0]   pos_idx;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   rotate;
    logic   clear;
    entry_t entry;
  } chain_ctrl_t;

endpackage
`default_nettype wire

// ===== design/stk_cell.sv =====
// stk_cell: one slot of the sorted chain; takes a broadcast insert, shifts
// from its left neighbor, or rotates from its right neighbor. Uses stk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stk_cell
  import stk_pkg::*;
(
  input  wire              clk,
  input  wire chain_ctrl_t ctrl,
  input  wire              occupied,
  input  wire              prev_take,
  input  wire entry_t      prev_entry,
  input  wire entry_t      next_entry,
  output logic             take,
  output entry_t           entry_r
);

  entry_t entry_nxt;

  // strict compare keeps earlier arrivals ahead on ties
  assign take = ctrl.insert && (!occupied || (ctrl.entry.score > entry_r.score));

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert) begin
      if (prev_take) begin
        entry_nxt = prev_entry;
      end else if (take) begin
        entry_nxt = ctrl.entry;
      end
    end else if (ctrl.rotate) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

// ===== design/stk_chain.sv =====
// stk_chain: row of CAPACITY stk_cell slots in descending score order plus
// the fill count. Uses stk_pkg and stk_cell.
`timescale 1ns / 1ps
`default_nettype none
module stk_chain
  import stk_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire chain_ctrl_t ctrl,
  output entry_t           head,
  output logic [CNT_W-1:0] count_r
);

  logic             take [CAPACITY];
  entry_t           ents [CAPACITY];
  logic [CNT_W-1:0] count_nxt;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      stk_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occupied  (CNT_W'(i) < count_r),
        .prev_take ((i == 0) ? 1'b0 : take[(i == 0) ? 0 : i - 1]),
        .prev_entry(ents[(i == 0) ? 0 : i - 1]),
        .next_entry(ents[(i + 1) % CAPACITY]),
        .take      (take[i]),
        .entry_r   (ents[i])
      );
    end
  endgenerate

  assign head = ents[0];

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clear) begin
      count_nxt = '0;
    end else if (ctrl.insert && (count_r != CNT_W'(CAPACITY))) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/streaming_top_k_selector.sv =====
// streaming_top_k_selector: top level; command decode, report sequencer,
// match counter and output register. Uses stk_pkg and stk_chain.
// Insert and clear: one beat per cycle, in_ready stays high while idle.
// Report: in_ready low while the chain rotates once through all cells, stalled
// while out_ready holds off a result beat; the first result beat passes the
// state register and then the output register. Sync active-low reset empties
// the store, zeroes the counter and sets report_count to 64.
`timescale 1ns / 1ps
`default_nettype none
module streaming_top_k_selector
  import stk_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [1:0]         in_kind,
  input  wire  [SCORE_W-1:0] in_score,
  input  wire  [TAG_W-1:0]   in_chunk_index,
  input  wire  [TAG_W-1:0]   in_local_index,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_valid_res,
  output logic [SCORE_W-1:0] out_score,
  output logic [TAG_W-1:0]   out_chunk,
  output logic [TAG_W-1:0]   out_local,
  output logic [TOTAL_W-1:0] out_matched_total,
  output logic               out_last,
  input  wire                cfg_wr_en,
  input  wire  [RPT_W-1:0]   cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REPORT = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [RPT_W-1:0]   rpt_cnt_r;
  logic [CNT_W-1:0]   num_r, num_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               ov_r, ov_nxt;
  logic               ov_res_r, ov_res_nxt;
  logic               ov_last_r, ov_last_nxt;
  entry_t             ov_ent_r, ov_ent_nxt;
  logic [TOTAL_W-1:0] ov_tot_r, ov_tot_nxt;

  chain_ctrl_t        ctrl;
  entry_t             head;
  logic [CNT_W-1:0]   count;
  logic               accept;
  logic               emit;
  logic               space;
  logic               advance;
  logic [RPT_W-1:0]   count_ext;

  stk_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .head   (head),
    .count_r(count)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign count_ext = RPT_W'(count);
  assign space     = !ov_r || out_ready;
  assign emit      = (num_r == '0) ? (step_r == '0)
                                   : (CNT_W'(step_r) < num_r);
  assign advance   = (state_r == ST_REPORT) && (!emit || space);

  always_comb begin
    ctrl.insert        = accept && (in_kind == KIND_INSERT) && (in_score != '0);
    ctrl.clear         = accept && (in_kind == KIND_CLEAR);
    ctrl.rotate        = advance;
    ctrl.entry.score   = in_score;
    ctrl.entry.chunk   = in_chunk_index;
    ctrl.entry.pos_idx = in_local_index;
  end

  always_comb begin
    state_nxt   = state_r;
    num_nxt     = num_r;
    step_nxt    = step_r;
    total_nxt   = total_r;
    ov_nxt      = ov_r && !out_ready;
    ov_res_nxt  = ov_res_r;
    ov_last_nxt = ov_last_r;
    ov_ent_nxt  = ov_ent_r;
    ov_tot_nxt  = ov_tot_r;
    case (state_r)
      ST_IDLE: begin
        if (ctrl.insert && (total_r != '1)) begin
          total_nxt = total_r + TOTAL_W'(1);
        end
        if (ctrl.clear) begin
          total_nxt = '0;
        end
        if (accept && (in_kind == KIND_REPORT)) begin
          num_nxt   = (rpt_cnt_r < count_ext) ? CNT_W'(rpt_cnt_r) : count;
          step_nxt  = '0;
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (advance) begin
          if (emit) begin
            ov_nxt      = 1'b1;
            ov_res_nxt  = (num_r != '0);
            ov_ent_nxt  = (num_r != '0) ? head : '0;
            ov_tot_nxt  = total_r;
            ov_last_nxt = (num_r == '0) || (CNT_W'(step_r) == num_r - CNT_W'(1));
          end
          if (step_r == IDX_W'(CAPACITY - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rpt_cnt_r <= RPT_RESET;
      total_r   <= '0;
      ov_r      <= 1'b0;
      num_r     <= '0;
      step_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        rpt_cnt_r <= cfg_wr_data;
      end
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
      num_r   <= num_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ov_res_r  <= ov_res_nxt;
    ov_last_r <= ov_last_nxt;
    ov_ent_r  <= ov_ent_nxt;
    ov_tot_r  <= ov_tot_nxt;
  end

  assign out_valid         = ov_r;
  assign out_valid_res     = ov_res_r;
  assign out_score         = ov_ent_r.score;
  assign out_chunk         = ov_ent_r.chunk;
  assign out_local         = ov_ent_r.pos_idx;
  assign out_matched_total = ov_tot_r;
  assign out_last          = ov_last_r;

endmodule
`default_nettype wire

// ===== dv/tb_streaming_top_k_selector.sv =====
// tb_streaming_top_k_selector: self-checking testbench for the top-k selector.
// Drives inserts, reports and clears under varied flow control and compares
// every report beat with a ranked shadow store. Depends on stk_pkg and the DUT.
`timescale 1ns / 1ps
module tb_streaming_top_k_selector;
  import stk_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic               has_entry;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   chunk;
    logic [TAG_W-1:0]   pos_idx;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } report_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind = KIND_INSERT;
  logic [SCORE_W-1:0] in_score = '0;
  logic [TAG_W-1:0]   in_chunk_index = '0;
  logic [TAG_W-1:0]   in_local_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_valid_res;
  logic [SCORE_W-1:0] out_score;
  logic [TAG_W-1:0]   out_chunk;
  logic [TAG_W-1:0]   out_local;
  logic [TOTAL_W-1:0] out_matched_total;
  logic               out_last;
  logic               cfg_wr_en = 1'b0;
  logic [RPT_W-1:0]   cfg_wr_data = '0;

  entry_t             ranked [CAPACITY];
  int                 ranked_count = 0;
  logic [TOTAL_W-1:0] match_count = '0;
  logic [RPT_W-1:0]   report_limit = RPT_RESET;
  report_beat_t       pending_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int cycle_count = 0;

  streaming_top_k_selector dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_score          (in_score),
    .in_chunk_index    (in_chunk_index),
    .in_local_index    (in_local_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_valid_res     (out_valid_res),
    .out_score         (out_score),
    .out_chunk         (out_chunk),
    .out_local         (out_local),
    .out_matched_total (out_matched_total),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("streaming_top_k_selector verification failed");
      $finish;
    end
  end

  // ---------------- shadow store ----------------
  function automatic void rank_insert(entry_t e);
    int n;
    int pos;
    n = ranked_count;
    if (n == CAPACITY) begin
      if (e.score <= ranked[CAPACITY-1].score) return;
      n = CAPACITY - 1;
    end
    pos = 0;
    while (pos < n && ranked[pos].score >= e.score) pos++;
    for (int i = n; i > pos; i--) ranked[i] = ranked[i-1];
    ranked[pos] = e;
    ranked_count = n + 1;
  endfunction

  function automatic void predict_beat(logic [1:0] kind, entry_t e);
    int n;
    report_beat_t r;
    case (kind)
      KIND_INSERT: begin
        if (e.score != 0) begin
          if (match_count != '1) match_count++;
          rank_insert(e);
        end
      end
      KIND_CLEAR: begin
        ranked_count = 0;
        match_count = '0;
      end
      KIND_REPORT: begin
        n = ranked_count;
        if (int'(report_limit) < n) n = int'(report_limit);
        if (n == 0) begin
          r = '0;
          r.total = match_count;
          r.last = 1'b1;
          pending_results = {pending_results, r};
        end else begin
          for (int k = 0; k < n; k++) begin
            r.has_entry = 1'b1;
            r.score = ranked[k].score;
            r.chunk = ranked[k].chunk;
            r.pos_idx = ranked[k].pos_idx;
            r.total = match_count;
            r.last = (k == n - 1);
            pending_results = {pending_results, r};
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------- result checking ----------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    report_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, expected none, got score 0x%0h last %0b",
                 $realtime, out_score, out_last);
      end else begin
        want = pending_results.pop_front();
        check_field("valid_res", 32'(want.has_entry), 32'(out_valid_res));
        check_field("score", 32'(want.score), 32'(out_score));
        check_field("chunk", 32'(want.chunk), 32'(out_chunk));
        check_field("local", 32'(want.pos_idx), 32'(out_local));
        check_field("matched_total", want.total, out_matched_total);
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------- stimulus helpers (called at a falling edge) ----------------
  task automatic send_beat(logic [1:0] kind, entry_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_score = e.score;
    in_chunk_index = e.chunk;
    in_local_index = e.pos_idx;
    do @(posedge clk); while (!in_ready);
    predict_beat(kind, e);
    if (kind != KIND_UNUSED) beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] kind, int score, int chunk, int pos_idx);
    entry_t e;
    e.score = SCORE_W'(score);
    e.chunk = TAG_W'(chunk);
    e.pos_idx = TAG_W'(pos_idx);
    send_beat(kind, e);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_report_limit(logic [RPT_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    report_limit = value;
  endtask

  // ---------------- tests ----------------
  task automatic test_directed_corners();
    send_fields(KIND_REPORT, 0, 0, 0);
    send_fields(KIND_INSERT, 0, 16'h1111, 16'h2222);
    send_fields(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fields(KIND_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fields(KIND_INSERT, 1, 0, 0);
    send_fields(KIND_INSERT, 16'h8000, 1, 2);
    send_fields(KIND_INSERT, 16'h8000, 3, 4);
    send_fields(KIND_INSERT, 16'h5555, 16'hAAAA, 16'h5555);
    send_fields(KIND_INSERT, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_fields(KIND_REPORT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fields(KIND_CLEAR, 0, 0, 0);
    send_fields(KIND_REPORT, 0, 0, 0);
    send_fields(KIND_INSERT, 16'h1234, 16'h0F0F, 16'hF0F0);
    send_fields(KIND_REPORT, 0, 0, 0);
  endtask

  task automatic test_report_limits();
    logic [RPT_W-1:0] limits [5];
    limits = '{7'd0, 7'd1, 7'd3, 7'd127, 7'd64};
    for (int i = 0; i < 4; i++) send_fields(KIND_INSERT, 16'h0100 + i, i, 16'h00FF);
    foreach (limits[i]) begin
      wait_drained();
      write_report_limit(limits[i]);
      send_fields(KIND_REPORT, 0, 0, 0);
    end
  endtask

  // fill past capacity with heavy ties, then beat the minimum
  task automatic test_full_store();
    wait_drained();
    write_report_limit(7'd64);
    send_fields(KIND_CLEAR, 0, 0, 0);
    for (int i = 0; i < 72; i++)
      send_fields(KIND_INSERT, $urandom_range(6, 1), i, $urandom);
    send_fields(KIND_INSERT, 1, 16'hDEAD, 16'hBEEF);
    send_fields(KIND_REPORT, 0, 0, 0);
    send_fields(KIND_INSERT, 7, 16'hCAFE, 16'h0001);
    send_fields(KIND_REPORT, 0, 0, 0);
    wait_drained();
    write_report_limit(7'd127);
    send_fields(KIND_REPORT, 0, 0, 0);
  endtask

  task automatic test_random_traffic(int beats, int idle_pct, int stall_pct,
                                     logic [RPT_W-1:0] limit);
    int done;
    int roll;
    bit narrow;
    entry_t e;
    wait_drained();
    write_report_limit(limit);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    narrow = 1'b0;
    while (done < beats) begin
      if (done % 40 == 0) narrow = 1'($urandom_range(1));
      roll = $urandom_range(99);
      e.score = narrow ? SCORE_W'($urandom_range(12, 1)) : SCORE_W'($urandom_range(65535, 1));
      e.chunk = TAG_W'($urandom);
      e.pos_idx = TAG_W'($urandom);
      if (roll < 1) begin
        send_beat(KIND_CLEAR, e);
      end else if (roll < 4) begin
        send_beat(KIND_UNUSED, e);
        continue;
      end else if (roll < 12) begin
        send_beat(KIND_REPORT, e);
      end else if (roll < 15) begin
        e.score = '0;
        send_beat(KIND_INSERT, e);
      end else begin
        send_beat(KIND_INSERT, e);
      end
      done++;
    end
  endtask

  // receiver holds off long enough for the selector to stall its input
  task automatic test_backpressure();
    wait_drained();
    write_report_limit(7'd64);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    for (int i = 0; i < 20; i++) send_fields(KIND_INSERT, $urandom_range(65535, 1), i, $urandom);
    send_fields(KIND_REPORT, 0, 0, 0);
    for (int i = 0; i < 20; i++) send_fields(KIND_INSERT, $urandom_range(65535, 1), i, $urandom);
    send_fields(KIND_REPORT, 0, 0, 0);
    send_fields(KIND_INSERT, 16'h4242, 16'h0042, 16'h4200);
    wait_drained();
    send_fields(KIND_REPORT, 0, 0, 0);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_directed_corners();
    test_report_limits();
    test_full_store();
    test_random_traffic(80, 0, 0, RPT_RESET);
    test_random_traffic(80, 46, 0, 7'd127);
    test_random_traffic(80, 0, 46, 7'($urandom_range(63, 2)));
    test_random_traffic(40, 12, 12, 7'd1);
    test_random_traffic(70, 12, 12, 7'd64);
    test_backpressure();
    wait_drained();
    $display("%0d beats sent, %0d result beats checked in %0d cycles", beats_sent,
             results_checked, cycle_count);
    $display("covered report limits 0 to 127, ties, full-store drops, clears and stalls");
    if (mismatch_count == 0) begin
      $display("streaming_top_k_selector verification clean");
    end else begin
      $display("streaming_top_k_selector verification failed");
    end
    $finish;
  end

endmodule

// ===== streaming_top_k_selector.f =====
design/stk_pkg.sv
design/stk_cell.sv
design/stk_chain.sv
design/streaming_top_k_selector.sv
dv/tb_streaming_top_k_selector.sv
